/* hdl/ppc_pkg.sv */
// ppc_pkg: widths, register indexes, limits and shared structs of the PID power controller.
// No dependencies; every ppc_* module imports it.
package ppc_pkg;

    localparam int MEAS_W  = 18;
    localparam int SP_W    = 8;
    localparam int GAIN_W  = 24;
    localparam int ERR_W   = 19;
    localparam int DERIV_W = 20;
    localparam int INTEG_W = 7;
    localparam int DRIVE_W = 8;
    localparam int FRAC_BITS = 16;

    localparam int P_ERR_W = ERR_W + GAIN_W;
    localparam int P_DER_W = DERIV_W + GAIN_W;
    localparam int P_INT_W = INTEG_W + GAIN_W;
    localparam int SUM_W   = 46;
    localparam int CLAMP_W = 24;

    localparam int SETPOINT_SCALE = 1000;
    localparam int INTEGRAL_LIMIT = 50;
    localparam int DRIVE_LIMIT    = 100;

    localparam int CFG_IDX_W = 4;
    localparam logic [CFG_IDX_W-1:0] REG_SETPOINT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I   = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D   = CFG_IDX_W'(3);

    localparam logic [SP_W-1:0]   SETPOINT_RST = SP_W'(5);
    localparam logic [GAIN_W-1:0] GAIN_P_RST   = GAIN_W'(13107);
    localparam logic [GAIN_W-1:0] GAIN_I_RST   = GAIN_W'(3277);
    localparam logic [GAIN_W-1:0] GAIN_D_RST   = GAIN_W'(0);

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [SP_W-1:0]   setpoint;
        logic [GAIN_W-1:0] gain_p;
        logic [GAIN_W-1:0] gain_i;
        logic [GAIN_W-1:0] gain_d;
    } t_cfg;

    // One classified sample: the three PID terms in milliwatts.
    typedef struct packed {
        logic [ERR_W-1:0]   err;
        logic [INTEG_W-1:0] integ;
        logic [DERIV_W-1:0] deriv;
    } t_item;

endpackage

/* hdl/ppc_regs.sv */
// ppc_regs: configuration register file (setpoint and the three Q16 gains).
// Depends on ppc_pkg.
module ppc_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [ppc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ppc_pkg::GAIN_W-1:0]    i_cfg_data,
    output ppc_pkg::t_cfg                 o_cfg
);
    import ppc_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.setpoint <= SETPOINT_RST;
            r_cfg.gain_p   <= GAIN_P_RST;
            r_cfg.gain_i   <= GAIN_I_RST;
            r_cfg.gain_d   <= GAIN_D_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_SETPOINT: r_cfg.setpoint <= i_cfg_data[SP_W-1:0];
                REG_GAIN_P:   r_cfg.gain_p   <= i_cfg_data;
                REG_GAIN_I:   r_cfg.gain_i   <= i_cfg_data;
                REG_GAIN_D:   r_cfg.gain_d   <= i_cfg_data;
                default: ; // unmapped index, write dropped
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* hdl/ppc_front.sv */
// ppc_front: accepts power samples, forms error, clamped integral and derivative.
// Depends on ppc_pkg; feeds ppc_queue.
module ppc_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  ppc_pkg::t_cfg              i_cfg,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [ppc_pkg::MEAS_W-1:0] i_measured_power_mw,
    input  logic                       i_queue_full,
    output logic                       o_push,
    output ppc_pkg::t_item             o_item
);
    import ppc_pkg::*;

    localparam logic signed [DERIV_W-1:0] ILIM_HI = DERIV_W'(INTEGRAL_LIMIT);
    localparam logic signed [DERIV_W-1:0] ILIM_LO = -DERIV_W'(INTEGRAL_LIMIT);

    logic signed [INTEG_W-1:0] r_integ, n_integ;
    logic signed [ERR_W-1:0]   r_prev_err;
    logic [MEAS_W-1:0]         sp_mw;
    logic signed [ERR_W-1:0]   err;
    logic signed [DERIV_W-1:0] integ_full;
    logic signed [DERIV_W-1:0] deriv;
    logic                      accept;

    assign o_in_ready = !i_queue_full;
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        sp_mw = {{(MEAS_W - SP_W){1'b0}}, i_cfg.setpoint} * MEAS_W'(SETPOINT_SCALE);
        err   = $signed({1'b0, sp_mw}) - $signed({1'b0, i_measured_power_mw});
        integ_full = $signed({{(DERIV_W - INTEG_W){r_integ[INTEG_W-1]}}, r_integ})
                   + $signed({{(DERIV_W - ERR_W){err[ERR_W-1]}}, err});
        if (integ_full > ILIM_HI) begin
            n_integ = INTEG_W'(INTEGRAL_LIMIT);
        end else if (integ_full < ILIM_LO) begin
            n_integ = -INTEG_W'(INTEGRAL_LIMIT);
        end else begin
            n_integ = integ_full[INTEG_W-1:0];
        end
        deriv = $signed({err[ERR_W-1], err}) - $signed({r_prev_err[ERR_W-1], r_prev_err});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ    <= '0;
            r_prev_err <= '0;
        end else if (accept) begin
            r_integ    <= n_integ;
            r_prev_err <= err;
        end
    end

    assign o_push       = accept;
    assign o_item.err   = err;
    assign o_item.integ = n_integ;
    assign o_item.deriv = deriv;

    a_integ_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_integ <= INTEG_W'(INTEGRAL_LIMIT)) && (r_integ >= -INTEG_W'(INTEGRAL_LIMIT)))
        else $error("integral left its clamp range");

endmodule

/* hdl/ppc_queue.sv */
// ppc_queue: short FIFO of classified samples between front and back.
// Depends on ppc_pkg.
module ppc_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ppc_pkg::t_item i_item,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output ppc_pkg::t_item o_item
);
    import ppc_pkg::*;

    t_item             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (i_pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from empty queue");

endmodule

/* hdl/ppc_back.sv */
// ppc_back: gain multiply, sum, clamp and truncate pipeline with output register.
// Depends on ppc_pkg; drains ppc_queue.
module ppc_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  ppc_pkg::t_cfg               i_cfg,
    input  logic                        i_q_valid,
    input  ppc_pkg::t_item              i_q_item,
    output logic                        o_pop,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [ppc_pkg::DRIVE_W-1:0] o_drive
);
    import ppc_pkg::*;

    localparam logic signed [SUM_W-1:0] LIM_HI = SUM_W'(DRIVE_LIMIT * (2 ** FRAC_BITS));
    localparam logic signed [SUM_W-1:0] LIM_LO = -SUM_W'(DRIVE_LIMIT * (2 ** FRAC_BITS));
    localparam logic signed [CLAMP_W-1:0] FRAC_MASK = CLAMP_W'((2 ** FRAC_BITS) - 1);

    logic signed [ERR_W-1:0]   err;
    logic signed [INTEG_W-1:0] integ;
    logic signed [DERIV_W-1:0] deriv;
    logic signed [GAIN_W-1:0]  gain_p, gain_i, gain_d;

    logic                      r_s1_vld, r_s2_vld, r_out_vld;
    logic signed [P_ERR_W-1:0] r_p_err;
    logic signed [P_INT_W-1:0] r_p_int;
    logic signed [P_DER_W-1:0] r_p_der;
    logic signed [SUM_W-1:0]   r_sum;
    logic [DRIVE_W-1:0]        r_drive, n_drive;
    logic signed [CLAMP_W-1:0] clamped, adj;
    logic                      out_free, s2_free, s1_free;

    assign err    = i_q_item.err;
    assign integ  = i_q_item.integ;
    assign deriv  = i_q_item.deriv;
    assign gain_p = i_cfg.gain_p;
    assign gain_i = i_cfg.gain_i;
    assign gain_d = i_cfg.gain_d;

    assign out_free = !r_out_vld || i_out_ready;
    assign s2_free  = !r_s2_vld || out_free;
    assign s1_free  = !r_s1_vld || s2_free;
    assign o_pop    = i_q_valid && s1_free;

    // clamp, then drop fraction bits toward zero (bias negatives up by the mask)
    always_comb begin
        if (r_sum > LIM_HI) begin
            clamped = LIM_HI[CLAMP_W-1:0];
        end else if (r_sum < LIM_LO) begin
            clamped = LIM_LO[CLAMP_W-1:0];
        end else begin
            clamped = r_sum[CLAMP_W-1:0];
        end
        adj     = clamped + (clamped[CLAMP_W-1] ? FRAC_MASK : '0);
        n_drive = adj[FRAC_BITS + DRIVE_W - 1:FRAC_BITS];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (s1_free)  r_s1_vld  <= i_q_valid;
            if (s2_free)  r_s2_vld  <= r_s1_vld;
            if (out_free) r_out_vld <= r_s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_p_err <= err * gain_p;
            r_p_int <= integ * gain_i;
            r_p_der <= deriv * gain_d;
        end
        if (s2_free && r_s1_vld) begin
            r_sum <= r_p_err + r_p_int + r_p_der;
        end
        if (out_free && r_s2_vld) begin
            r_drive <= n_drive;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_drive     = r_drive;

    a_drive_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (($signed(o_drive) <= DRIVE_W'(DRIVE_LIMIT))
                      && ($signed(o_drive) >= -DRIVE_W'(DRIVE_LIMIT))))
        else $error("drive outside saturation range");

endmodule

/* hdl/pid_power_controller_top.sv */
// pid_power_controller_top: PID loop on a stream of milliwatt power samples.
// Depends on ppc_pkg, ppc_regs, ppc_front, ppc_queue, ppc_back.
//
// One drive value comes out for every power sample that goes in, in order. Samples
// are taken at one per clock while the queue is not full: the front stage computes
// error (setpoint * 1000 minus the sample), the clamped integral (+/-50) and the
// error difference in the cycle the beat is accepted, since that is the only state
// carried from sample to sample. A four-entry queue then decouples it from the back
// pipeline, which multiplies the three terms by their signed Q16 gains, sums them,
// clamps to +/-100.0 and truncates toward zero. Output valid is registered: the
// queue is written at the accepting edge, then the multiply stage, sum stage and
// output register follow; throughput is one beat per cycle as long as the output
// side takes beats. A stall downstream backs up through the back pipeline, then the
// queue, and only then drops o_in_ready. Configuration writes (index 0 setpoint in
// watts, 1..3 the P, I, D gains, other indexes ignored) take effect on the next edge
// and must only be issued while the block is empty.
module pid_power_controller_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // config write port
    input  logic                          i_cfg_we,
    input  logic [ppc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ppc_pkg::GAIN_W-1:0]    i_cfg_data,
    // sample channel
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [ppc_pkg::MEAS_W-1:0]    i_measured_power_mw,
    // drive channel
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [ppc_pkg::DRIVE_W-1:0]   o_drive
);
    import ppc_pkg::*;

    t_cfg  cfg;
    t_item front_item, q_item;
    logic  push, pop, q_full, q_valid;

    ppc_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // front: classify the beat and update the integral / previous error
    ppc_front u_front (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg               (cfg),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_measured_power_mw (i_measured_power_mw),
        .i_queue_full        (q_full),
        .o_push              (push),
        .o_item              (front_item)
    );

    ppc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    // back: gain multiply, sum, saturate, truncate
    ppc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_q_valid   (q_valid),
        .i_q_item    (q_item),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_drive     (o_drive)
    );

endmodule

/* dv/testbench.sv */
// testbench: self-checking bench for pid_power_controller_top.
// Depends on ppc_pkg and the RTL; an internal PID predictor checks every drive beat.

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ppc_pkg::*;

    // Unused register indexes: writes there must leave the block unchanged.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_FIRST = REG_GAIN_D + 1'b1;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LAST  = '1;
    localparam logic [GAIN_W-1:0]    GAIN_MAX  = {1'b0, {(GAIN_W-1){1'b1}}};
    localparam logic [GAIN_W-1:0]    GAIN_MIN  = {1'b1, {(GAIN_W-1){1'b0}}};
    localparam logic [MEAS_W-1:0]    MEAS_MAX  = '1;
    localparam int                   PIPE_LAT  = 4;     // beat in to drive valid
    localparam int                   DRAIN_MAX = 5000;  // cycles allowed for a drain

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [GAIN_W-1:0]    i_cfg_data = '0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    logic [MEAS_W-1:0]    i_measured_power_mw = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic [DRIVE_W-1:0]   o_drive;

    pid_power_controller_top dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_measured_power_mw (i_measured_power_mw),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_drive             (o_drive)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Predictor state: a shadow of the config registers and the loop memory.
    logic [SP_W-1:0]          cfg_setpoint = SETPOINT_RST;
    logic signed [GAIN_W-1:0] cfg_kp = GAIN_P_RST;
    logic signed [GAIN_W-1:0] cfg_ki = GAIN_I_RST;
    logic signed [GAIN_W-1:0] cfg_kd = GAIN_D_RST;
    longint                   integ_acc = 0;
    longint                   err_prev = 0;

    logic [DRIVE_W-1:0] drive_expected[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int n_samples = 0;
    int n_drives = 0;
    int n_cfg_writes = 0;
    int n_sat_hi = 0;
    int n_sat_lo = 0;
    int n_fail = 0;

    // Mirror of one register write; bits above a register's width are dropped.
    function automatic void shadow_write(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [GAIN_W-1:0] data);
        case (idx)
            REG_SETPOINT: cfg_setpoint = data[SP_W-1:0];
            REG_GAIN_P:   cfg_kp = data;
            REG_GAIN_I:   cfg_ki = data;
            REG_GAIN_D:   cfg_kd = data;
            default: ;
        endcase
    endfunction

    // One PID step: error in mW, integral clamped to +/-50, derivative of the
    // error, Q16 weighted sum clamped to +/-100.0, then truncated toward zero.
    function automatic logic [DRIVE_W-1:0] pid_drive_step(input logic [MEAS_W-1:0] mw);
        longint err, integ, deriv, acc, lim, drv;
        lim = longint'(DRIVE_LIMIT) <<< FRAC_BITS;
        err = longint'(cfg_setpoint) * SETPOINT_SCALE - longint'(mw);
        integ = integ_acc + err;
        if (integ > INTEGRAL_LIMIT)
            integ = INTEGRAL_LIMIT;
        if (integ < -INTEGRAL_LIMIT)
            integ = -INTEGRAL_LIMIT;
        integ_acc = integ;
        deriv = err - err_prev;
        err_prev = err;
        acc = err * longint'(cfg_kp) + integ * longint'(cfg_ki) + deriv * longint'(cfg_kd);
        if (acc >= lim) begin
            acc = lim;
            n_sat_hi++;
        end
        if (acc <= -lim) begin
            acc = -lim;
            n_sat_lo++;
        end
        if (acc < 0)
            drv = -((-acc) >>> FRAC_BITS);
        else
            drv = acc >>> FRAC_BITS;
        return DRIVE_W'(drv);
    endfunction

    // Drive side: ready toggles at random per the current receiver idle rate.
    always @(posedge i_clk) begin
        i_out_ready <= (int'($urandom_range(99)) >= recv_idle_pct);
    end

    // Drive beat checker: every accepted beat must match the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            n_drives++;
            if (drive_expected.size() == 0) begin
                $error("drive beat %0d with no sample outstanding", $signed(o_drive));
                n_fail++;
            end else begin
                if (o_drive !== drive_expected[0]) begin
                    $error("drive mismatch: expected %0d, actual %0d",
                           $signed(drive_expected[0]), $signed(o_drive));
                    n_fail++;
                end
                void'(drive_expected.pop_front());
            end
        end
    end

    // Sample beat. Valid is left high after acceptance so back-to-back beats
    // never lower and raise it in one step; idling or draining drops it.
    task automatic send_sample(input logic [MEAS_W-1:0] mw);
        while (int'($urandom_range(99)) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_measured_power_mw <= mw;
        do
            @(posedge i_clk);
        while (!o_in_ready);
        drive_expected.push_back(pid_drive_step(mw));
        n_samples++;
    endtask

    // Stop sending, wait for every outstanding drive, then let the pipe settle.
    task automatic drain_pipe();
        int guard;
        guard = 0;
        i_in_valid <= 1'b0;
        while (drive_expected.size() != 0 && guard < DRAIN_MAX) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (PIPE_LAT + 2) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        shadow_write(idx, data);
        n_cfg_writes++;
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [GAIN_W-1:0] pick_gain();
        case ($urandom_range(0, 7))
            0:       return GAIN_MAX;
            1:       return GAIN_MIN;
            2:       return '0;
            3:       return GAIN_W'($urandom());
            default: return GAIN_W'(int'($urandom_range(0, 80000)) - 40000);
        endcase
    endfunction

    // Mostly samples near the setpoint so the loop stays out of saturation.
    function automatic logic [MEAS_W-1:0] pick_sample();
        int v;
        v = int'(cfg_setpoint) * SETPOINT_SCALE;
        case ($urandom_range(0, 9)) inside
            0, 1:    return MEAS_W'($urandom());
            2:       return $urandom_range(0, 1) ? MEAS_MAX : '0;
            3, 4, 5: v += int'($urandom_range(0, 1200)) - 600;
            default: v += int'($urandom_range(0, 100)) - 50;
        endcase
        if (v < 0)
            v = 0;
        if (v > int'(MEAS_MAX))
            v = int'(MEAS_MAX);
        return MEAS_W'(v);
    endfunction

    // New random setting; setpoint data carries junk in its upper bits.
    task automatic load_random_config();
        logic [SP_W-1:0] sp;
        case ($urandom_range(0, 5))
            0:       sp = '0;
            1:       sp = '1;
            default: sp = SP_W'($urandom());
        endcase
        cfg_write(REG_SETPOINT, {(GAIN_W-SP_W)'($urandom()), sp});
        cfg_write(REG_GAIN_P, pick_gain());
        cfg_write(REG_GAIN_I, pick_gain());
        cfg_write(REG_GAIN_D, pick_gain());
        if ($urandom_range(0, 2) == 0)
            cfg_write(CFG_IDX_W'($urandom_range(REG_UNUSED_FIRST, REG_UNUSED_LAST)),
                      GAIN_W'($urandom()));
    endtask

    // Reset values: zero error, full positive and negative error, small steps.
    task automatic test_reset_config();
        send_sample(MEAS_W'(5000));
        send_sample('0);
        send_sample(MEAS_MAX);
        send_sample(MEAS_W'(4990));
        send_sample(MEAS_W'(5010));
        send_sample(MEAS_W'(5000));
        drain_pipe();
    endtask

    // Gain extremes, setpoint top, integral clamps on both sides.
    task automatic test_gain_extremes();
        cfg_write(REG_SETPOINT, {16'hABCD, 8'hFF});
        cfg_write(REG_GAIN_P, GAIN_MAX);
        cfg_write(REG_GAIN_I, GAIN_MIN);
        cfg_write(REG_GAIN_D, GAIN_W'(1));
        send_sample(MEAS_W'(255000));
        send_sample(MEAS_W'(255001));
        send_sample(MEAS_W'(254999));
        send_sample('0);
        send_sample(MEAS_MAX);
        drain_pipe();
    endtask

    // Negative fractions must truncate toward zero, not floor.
    task automatic test_truncation();
        cfg_write(REG_SETPOINT, '0);
        cfg_write(REG_GAIN_P, '1);                  // -1/65536
        cfg_write(REG_GAIN_I, '0);
        cfg_write(REG_GAIN_D, GAIN_W'(-98304));     // -1.5
        send_sample(MEAS_W'(1));
        send_sample(MEAS_W'(1));
        send_sample(MEAS_W'(2));
        send_sample('0);
        send_sample(MEAS_W'(3));
        drain_pipe();
    endtask

    // Writes to unused indexes are dropped.
    task automatic test_unused_index();
        cfg_write(REG_SETPOINT, GAIN_W'(7));
        cfg_write(REG_GAIN_P, GAIN_W'(13107));
        cfg_write(REG_GAIN_I, GAIN_W'(3277));
        cfg_write(REG_GAIN_D, GAIN_W'(6554));
        cfg_write(REG_UNUSED_FIRST, GAIN_MAX);
        cfg_write(REG_UNUSED_LAST, GAIN_MIN);
        send_sample(MEAS_W'(6900));
        send_sample(MEAS_W'(7100));
        send_sample(MEAS_W'(7000));
        drain_pipe();
    endtask

    // Random samples under a fresh setting every 60 beats; each reconfig
    // pauses the sender until the pipe is empty.
    task automatic test_random_stream(input int n, input int snd_pct, input int rcv_pct);
        send_idle_pct = snd_pct;
        recv_idle_pct = rcv_pct;
        for (int k = 0; k < n; k++) begin
            if (k % 60 == 0) begin
                drain_pipe();
                load_random_config();
            end
            send_sample(pick_sample());
        end
        drain_pipe();
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_config();
        test_gain_extremes();
        test_truncation();
        test_unused_index();
        test_random_stream(280, 26, 46);
        test_random_stream(280, 46, 26);
        test_random_stream(280, 0, 0);

        if (drive_expected.size() != 0) begin
            $error("%0d drive beats never arrived", drive_expected.size());
            n_fail++;
        end
        $display("Covered %0d power samples, %0d drive beats, %0d register writes.",
                 n_samples, n_drives, n_cfg_writes);
        $display("Drive clamped at the top %0d times and at the bottom %0d times.",
                 n_sat_hi, n_sat_lo);
        if (n_fail == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #3_000_000;
        $display("testbench NOT OK");
        $finish;
    end

endmodule
